@@ design/bfc_pkg.sv @@
// Shared types, constants and helpers of the bidirectional flow counter.
// Used by bfc_ctrl, bfc_datapath, the top level and bfc_checker.
package bfc_pkg;

  localparam int FLOW_ENTRIES = 4096;
  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [5:0] MIN_IP_HEADER = 6'd20;
  localparam logic [7:0] ETH_HEADER = 8'd14;
  localparam logic [7:0] UDP_HEADER = 8'd8;

  typedef enum logic [2:0] {
    STAT_BAD_IP = 3'd0,
    STAT_OTHER  = 3'd1,
    STAT_KNOWN  = 3'd2,
    STAT_NEW    = 3'd3,
    STAT_FULL   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SEARCH,
    ST_COMMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic classify;
    logic search_clr;
    logic search_run;
    logic commit;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic flow_frame;
    logic search_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [31:0] addr_a;
    logic [31:0] addr_b;
    logic [15:0] port_a;
    logic [15:0] port_b;
    logic        udp;
  } flow_entry_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

@@ design/bfc_ctrl.sv @@
// Sequencer of the flow counter: accept, classify, table search, commit, result.
// Depends on bfc_pkg.
module bfc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  bfc_pkg::sts_t  sts,
  output bfc_pkg::cmd_t  cmd
);

  bfc_pkg::state_t state;
  bfc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bfc_pkg::ST_IDLE: begin
        if (in_valid) state_next = bfc_pkg::ST_CLASSIFY;
      end
      bfc_pkg::ST_CLASSIFY: begin
        state_next = sts.flow_frame ? bfc_pkg::ST_SEARCH : bfc_pkg::ST_FINISH;
      end
      bfc_pkg::ST_SEARCH: begin
        if (sts.search_done) state_next = bfc_pkg::ST_COMMIT;
      end
      bfc_pkg::ST_COMMIT: begin
        state_next = bfc_pkg::ST_FINISH;
      end
      bfc_pkg::ST_FINISH: begin
        if (sts.out_free) state_next = bfc_pkg::ST_IDLE;
      end
      default: begin
        state_next = bfc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      bfc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      bfc_pkg::ST_CLASSIFY: begin
        cmd.classify = 1'b1;
        cmd.search_clr = 1'b1;
      end
      bfc_pkg::ST_SEARCH: begin
        cmd.search_run = 1'b1;
      end
      bfc_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      bfc_pkg::ST_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ design/bfc_datapath.sv @@
// Datapath: input capture, header arithmetic, saturating counters, flow table
// memory with pipelined linear search, and the result register. Depends on bfc_pkg.
module bfc_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bfc_pkg::cmd_t        cmd,
  output bfc_pkg::sts_t        sts,
  input  logic [7:0]           ip_protocol,
  input  logic [3:0]           ip_header_words,
  input  logic [3:0]           tcp_offset_words,
  input  logic [31:0]          source_address,
  input  logic [31:0]          destination_address,
  input  logic [15:0]          source_port,
  input  logic [15:0]          destination_port,
  input  logic [15:0]          frame_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           status,
  output logic [31:0]          total_packets,
  output logic [31:0]          tcp_packets,
  output logic [31:0]          udp_packets,
  output logic [31:0]          tcp_payload_bytes,
  output logic [31:0]          udp_payload_bytes,
  output logic [12:0]          tcp_flow_count,
  output logic [12:0]          udp_flow_count
);

  // captured item
  logic [7:0]  proto;
  logic [3:0]  ihl;
  logic [3:0]  doff;
  logic [31:0] saddr;
  logic [31:0] daddr;
  logic [15:0] sport;
  logic [15:0] dport;
  logic [15:0] flen;

  // running state
  logic [31:0] pkt_total;
  logic [31:0] pkt_tcp;
  logic [31:0] pkt_udp;
  logic [31:0] bytes_tcp;
  logic [31:0] bytes_udp;
  logic [12:0] flows_tcp;
  logic [12:0] flows_udp;
  logic [bfc_pkg::CNT_W-1:0] used;
  bfc_pkg::status_t st;

  // search
  logic [bfc_pkg::CNT_W-1:0] idx;
  logic pend;
  logic hit;
  bfc_pkg::flow_entry_t rd_data;
  bfc_pkg::flow_entry_t mem [bfc_pkg::FLOW_ENTRIES];

  logic        is_tcp;
  logic        is_udp;
  logic [5:0]  ip_bytes;
  logic        bad_ip;
  logic [7:0]  hdr_len;
  logic [15:0] payload;
  logic        rd_en;
  logic        match;
  logic        full;
  logic        mem_we;
  bfc_pkg::flow_entry_t wr_entry;

  always_comb begin
    is_tcp   = (proto == bfc_pkg::PROTO_TCP);
    is_udp   = (proto == bfc_pkg::PROTO_UDP);
    ip_bytes = {ihl, 2'b00};
    bad_ip   = (ip_bytes < bfc_pkg::MIN_IP_HEADER);
    hdr_len  = bfc_pkg::ETH_HEADER + {2'b00, ip_bytes}
             + (is_udp ? bfc_pkg::UDP_HEADER : {2'b00, doff, 2'b00});
    payload  = (flen > {8'h00, hdr_len}) ? (flen - {8'h00, hdr_len}) : 16'h0000;

    rd_en = cmd.search_run && (idx < used);
    match = (rd_data.udp == is_udp)
         && (((rd_data.addr_a == saddr) && (rd_data.addr_b == daddr)
              && (rd_data.port_a == sport) && (rd_data.port_b == dport))
          || ((rd_data.addr_a == daddr) && (rd_data.addr_b == saddr)
              && (rd_data.port_a == dport) && (rd_data.port_b == sport)));
    full = (used == bfc_pkg::CNT_W'(bfc_pkg::FLOW_ENTRIES));
    mem_we = cmd.commit && !hit && !full;

    wr_entry.addr_a = saddr;
    wr_entry.addr_b = daddr;
    wr_entry.port_a = sport;
    wr_entry.port_b = dport;
    wr_entry.udp    = is_udp;

    sts.flow_frame  = !bad_ip && (is_tcp || is_udp);
    sts.search_done = hit || (!(idx < used) && !pend);
    sts.out_free    = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      proto <= ip_protocol;
      ihl   <= ip_header_words;
      doff  <= tcp_offset_words;
      saddr <= source_address;
      daddr <= destination_address;
      sport <= source_port;
      dport <= destination_port;
      flen  <= frame_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_total <= '0;
      pkt_tcp   <= '0;
      pkt_udp   <= '0;
      bytes_tcp <= '0;
      bytes_udp <= '0;
      flows_tcp <= '0;
      flows_udp <= '0;
      used      <= '0;
      st        <= bfc_pkg::STAT_BAD_IP;
    end else begin
      if (cmd.classify) begin
        pkt_total <= bfc_pkg::sat_add32(pkt_total, 32'd1);
        if (bad_ip) begin
          st <= bfc_pkg::STAT_BAD_IP;
        end else if (is_tcp) begin
          pkt_tcp   <= bfc_pkg::sat_add32(pkt_tcp, 32'd1);
          bytes_tcp <= bfc_pkg::sat_add32(bytes_tcp, {16'h0000, payload});
        end else if (is_udp) begin
          pkt_udp   <= bfc_pkg::sat_add32(pkt_udp, 32'd1);
          bytes_udp <= bfc_pkg::sat_add32(bytes_udp, {16'h0000, payload});
        end else begin
          st <= bfc_pkg::STAT_OTHER;
        end
      end
      if (cmd.commit) begin
        if (hit) begin
          st <= bfc_pkg::STAT_KNOWN;
        end else if (full) begin
          st <= bfc_pkg::STAT_FULL;
        end else begin
          st   <= bfc_pkg::STAT_NEW;
          used <= used + bfc_pkg::CNT_W'(1);
          if (is_udp) begin
            if (flows_udp != 13'h1FFF) flows_udp <= flows_udp + 13'd1;
          end else begin
            if (flows_tcp != 13'h1FFF) flows_tcp <= flows_tcp + 13'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      pend <= 1'b0;
      hit  <= 1'b0;
    end else if (cmd.search_clr) begin
      idx  <= '0;
      pend <= 1'b0;
      hit  <= 1'b0;
    end else if (cmd.search_run) begin
      pend <= rd_en;
      if (rd_en) idx <= idx + bfc_pkg::CNT_W'(1);
      if (pend && match) hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[used[bfc_pkg::IDX_W-1:0]] <= wr_entry;
    if (rd_en) rd_data <= mem[idx[bfc_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status            <= st;
      total_packets     <= pkt_total;
      tcp_packets       <= pkt_tcp;
      udp_packets       <= pkt_udp;
      tcp_payload_bytes <= bytes_tcp;
      udp_payload_bytes <= bytes_udp;
      tcp_flow_count    <= flows_tcp;
      udp_flow_count    <= flows_udp;
    end
  end

endmodule

@@ design/bidirectional_flow_counter.sv @@
// Top level of the bidirectional flow counter: bfc_ctrl sequences bfc_datapath.
// Depends on bfc_pkg, bfc_ctrl and bfc_datapath.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+----------------------------------------------
//   in      | in_valid, in_stall | ip_protocol .. frame_length (header fields)
//   out     | out_valid, out_stall | status and the seven counters
//
// A bad header or other protocol goes from classify straight to the finish
// step; for TCP/UDP the stored flows are compared first (a hit ends the scan
// early), through the single read port of the flow table memory, one entry per
// cycle, and the result is then committed.
// Reset clears the counters and the fill count; table contents need no clearing.
// A new frame is taken while the previous result waits in the output register;
// a stalled result holds the next one in the finish step.
module bidirectional_flow_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ip_protocol,
  input  logic [3:0]  ip_header_words,
  input  logic [3:0]  tcp_offset_words,
  input  logic [31:0] source_address,
  input  logic [31:0] destination_address,
  input  logic [15:0] source_port,
  input  logic [15:0] destination_port,
  input  logic [15:0] frame_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] total_packets,
  output logic [31:0] tcp_packets,
  output logic [31:0] udp_packets,
  output logic [31:0] tcp_payload_bytes,
  output logic [31:0] udp_payload_bytes,
  output logic [12:0] tcp_flow_count,
  output logic [12:0] udp_flow_count
);

  bfc_pkg::cmd_t cmd;
  bfc_pkg::sts_t sts;

  bfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfc_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .sts                 (sts),
    .ip_protocol         (ip_protocol),
    .ip_header_words     (ip_header_words),
    .tcp_offset_words    (tcp_offset_words),
    .source_address      (source_address),
    .destination_address (destination_address),
    .source_port         (source_port),
    .destination_port    (destination_port),
    .frame_length        (frame_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .status              (status),
    .total_packets       (total_packets),
    .tcp_packets         (tcp_packets),
    .udp_packets         (udp_packets),
    .tcp_payload_bytes   (tcp_payload_bytes),
    .udp_payload_bytes   (udp_payload_bytes),
    .tcp_flow_count      (tcp_flow_count),
    .udp_flow_count      (udp_flow_count)
  );

endmodule

@@ design/bfc_checker.sv @@
// Port-level checks of the bidirectional flow counter, bound to the top level.
// Depends on bfc_pkg.
module bfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [31:0] total_packets,
  input logic [12:0] tcp_flow_count,
  input logic [12:0] udp_flow_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> total_packets != 32'd0)
    else $error("result with zero packet count");

  a_new_flow_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == bfc_pkg::STAT_NEW
      |-> (tcp_flow_count != 13'd0) || (udp_flow_count != 13'd0))
    else $error("new flow with empty flow counts");

endmodule

bind bidirectional_flow_counter bfc_checker u_bfc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .total_packets  (total_packets),
  .tcp_flow_count (tcp_flow_count),
  .udp_flow_count (udp_flow_count)
);

@@ bench/tb_bidirectional_flow_counter.sv @@
// Self-checking bench for bidirectional_flow_counter: directed and random header transfers.
// Each transfer is checked against a predictor of the packet, byte and flow counts.
// Depends on bfc_pkg and the bidirectional_flow_counter RTL.
module tb_bidirectional_flow_counter;

  localparam int RANDOM_FRAMES = 120;
  localparam int POOL_SIZE = 24;
  localparam int HOLD_OFF = 300;
  localparam int DRAIN = 40;
  localparam int LIMIT = 400000;
  localparam logic [12:0] FLOW_CAP = 13'h1FFF;
  localparam logic [7:0] PROTO_TCP = bfc_pkg::PROTO_TCP;
  localparam logic [7:0] PROTO_UDP = bfc_pkg::PROTO_UDP;

  typedef struct packed {
    logic [7:0]  proto;
    logic [3:0]  ip_words;
    logic [3:0]  tcp_words;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] from_port;
    logic [15:0] to_port;
    logic [15:0] frame_len;
  } frame_hdr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] total;
    logic [31:0] tcp_pkts;
    logic [31:0] udp_pkts;
    logic [31:0] tcp_bytes;
    logic [31:0] udp_bytes;
    logic [12:0] tcp_flows;
    logic [12:0] udp_flows;
  } tally_t;

  typedef struct packed {
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic        udp;
  } flow_key_t;

  class flow_count_model;
    bfc_pkg::flow_entry_t flows[$];
    tally_t      counts;
    tally_t      pending_tallies[$];
    int          errors;
    int          checked;
    int          by_status[5];

    function new();
      counts = '0;
      errors = 0;
      checked = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [31:0] s;
      s = a + b;
      return (s < a) ? 32'hFFFF_FFFF : s;
    endfunction

    function bit flow_known(frame_hdr_t f, bit udp);
      foreach (flows[i]) begin
        if (flows[i].udp != udp) continue;
        if (flows[i].addr_a == f.src_addr && flows[i].addr_b == f.dst_addr &&
            flows[i].port_a == f.from_port && flows[i].port_b == f.to_port)
          return 1'b1;
        if (flows[i].addr_a == f.dst_addr && flows[i].addr_b == f.src_addr &&
            flows[i].port_a == f.to_port && flows[i].port_b == f.from_port)
          return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_frame(frame_hdr_t f);
      bit udp;
      int hdr;
      int payload;
      bfc_pkg::flow_entry_t e;
      counts.total = sat_sum(counts.total, 32'd1);
      if (int'(f.ip_words) * 4 < int'(bfc_pkg::MIN_IP_HEADER)) begin
        counts.status = bfc_pkg::STAT_BAD_IP;
      end else if (f.proto != PROTO_TCP && f.proto != PROTO_UDP) begin
        counts.status = bfc_pkg::STAT_OTHER;
      end else begin
        udp = (f.proto == PROTO_UDP);
        hdr = int'(bfc_pkg::ETH_HEADER) + int'(f.ip_words) * 4 +
              (udp ? int'(bfc_pkg::UDP_HEADER) : int'(f.tcp_words) * 4);
        payload = (int'(f.frame_len) > hdr) ? int'(f.frame_len) - hdr : 0;
        if (udp) begin
          counts.udp_pkts = sat_sum(counts.udp_pkts, 32'd1);
          counts.udp_bytes = sat_sum(counts.udp_bytes, 32'(payload));
        end else begin
          counts.tcp_pkts = sat_sum(counts.tcp_pkts, 32'd1);
          counts.tcp_bytes = sat_sum(counts.tcp_bytes, 32'(payload));
        end
        if (flow_known(f, udp)) begin
          counts.status = bfc_pkg::STAT_KNOWN;
        end else if (flows.size() >= bfc_pkg::FLOW_ENTRIES) begin
          counts.status = bfc_pkg::STAT_FULL;
        end else begin
          e.addr_a = f.src_addr;
          e.addr_b = f.dst_addr;
          e.port_a = f.from_port;
          e.port_b = f.to_port;
          e.udp = udp;
          flows.push_back(e);
          if (udp && counts.udp_flows < FLOW_CAP) counts.udp_flows++;
          if (!udp && counts.tcp_flows < FLOW_CAP) counts.tcp_flows++;
          counts.status = bfc_pkg::STAT_NEW;
        end
      end
      pending_tallies.push_back(counts);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_tally(tally_t got);
      tally_t want;
      if (pending_tallies.size() == 0) begin
        $error("result with no transfer pending: status %0d", got.status);
        errors++;
        return;
      end
      want = pending_tallies.pop_front();
      checked++;
      if (want.status < 5) by_status[want.status]++;
      cmp("status", 32'(want.status), 32'(got.status));
      cmp("total_packets", want.total, got.total);
      cmp("tcp_packets", want.tcp_pkts, got.tcp_pkts);
      cmp("udp_packets", want.udp_pkts, got.udp_pkts);
      cmp("tcp_payload_bytes", want.tcp_bytes, got.tcp_bytes);
      cmp("udp_payload_bytes", want.udp_bytes, got.udp_bytes);
      cmp("tcp_flow_count", 32'(want.tcp_flows), 32'(got.tcp_flows));
      cmp("udp_flow_count", 32'(want.udp_flows), 32'(got.udp_flows));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  ip_protocol = '0;
  logic [3:0]  ip_header_words = '0;
  logic [3:0]  tcp_offset_words = '0;
  logic [31:0] source_address = '0;
  logic [31:0] destination_address = '0;
  logic [15:0] source_port = '0;
  logic [15:0] destination_port = '0;
  logic [15:0] frame_length = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [31:0] total_packets;
  logic [31:0] tcp_packets;
  logic [31:0] udp_packets;
  logic [31:0] tcp_payload_bytes;
  logic [31:0] udp_payload_bytes;
  logic [12:0] tcp_flow_count;
  logic [12:0] udp_flow_count;

  flow_count_model model = new();
  int cycles = 0;
  int tx_calm = 0;
  int rx_calm = 0;
  bit held = 1'b0;

  bidirectional_flow_counter DUT (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .ip_protocol         (ip_protocol),
    .ip_header_words     (ip_header_words),
    .tcp_offset_words    (tcp_offset_words),
    .source_address      (source_address),
    .destination_address (destination_address),
    .source_port         (source_port),
    .destination_port    (destination_port),
    .frame_length        (frame_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .status              (status),
    .total_packets       (total_packets),
    .tcp_packets         (tcp_packets),
    .udp_packets         (udp_packets),
    .tcp_payload_bytes   (tcp_payload_bytes),
    .udp_payload_bytes   (udp_payload_bytes),
    .tcp_flow_count      (tcp_flow_count),
    .udp_flow_count      (udp_flow_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("** bidirectional_flow_counter: FAILED **");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, and runs with none
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(10, 25);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic frame_hdr_t mk(logic [7:0] proto, logic [3:0] ip_words,
                                    logic [3:0] tcp_words, logic [31:0] sa,
                                    logic [31:0] da, logic [15:0] sp,
                                    logic [15:0] dp, logic [15:0] frame_len);
    frame_hdr_t f;
    f.proto = proto;
    f.ip_words = ip_words;
    f.tcp_words = tcp_words;
    f.src_addr = sa;
    f.dst_addr = da;
    f.from_port = sp;
    f.to_port = dp;
    f.frame_len = frame_len;
    return f;
  endfunction

  task automatic send_frame(input frame_hdr_t f);
    int gap;
    gap = idle_len(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ip_protocol <= f.proto;
    ip_header_words <= f.ip_words;
    tcp_offset_words <= f.tcp_words;
    source_address <= f.src_addr;
    destination_address <= f.dst_addr;
    source_port <= f.from_port;
    destination_port <= f.to_port;
    frame_length <= f.frame_len;
    do @(posedge clk); while (in_stall !== 1'b0);
    model.note_frame(f);
  endtask

  always @(posedge clk) begin
    tally_t got;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{status, total_packets, tcp_packets, udp_packets, tcp_payload_bytes,
              udp_payload_bytes, tcp_flow_count, udp_flow_count};
      model.check_tally(got);
    end
  end

  // receiver: random stalls plus one long hold-off that backs up the block
  initial begin
    int n;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (!held && model.checked >= 30) begin
        held = 1'b1;
        n = HOLD_OFF;
      end else begin
        n = idle_len(rx_calm);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    flow_key_t pool[POOL_SIZE];
    flow_key_t k;
    frame_hdr_t f;
    int r;
    bit swap;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bad headers, other protocols, flow hits in both directions, payload clamp
    send_frame(mk(PROTO_TCP, 4'd0, 4'd5, '0, '0, '0, '0, '0));
    send_frame(mk(PROTO_UDP, 4'd4, 4'd15, '1, '1, '1, '1, '1));
    send_frame(mk(8'd0, 4'd5, 4'd0, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd81, 16'd60));
    send_frame(mk(8'hFF, 4'd15, 4'd15, '1, '0, '1, '0, 16'd1500));
    send_frame(mk(8'd7, 4'd5, 4'd5, 32'h1, 32'h2, 16'd3, 16'd4, 16'd100));
    send_frame(mk(8'd16, 4'd5, 4'd5, 32'h1, 32'h2, 16'd3, 16'd4, 16'd100));
    send_frame(mk(8'd18, 4'd5, 4'd5, 32'h1, 32'h2, 16'd3, 16'd4, 16'd100));
    send_frame(mk(PROTO_TCP, 4'd5, 4'd5, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'hFFFF));
    send_frame(mk(PROTO_TCP, 4'd5, 4'd5, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'd54));
    send_frame(mk(PROTO_TCP, 4'd6, 4'd8, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 16'd200));
    send_frame(mk(PROTO_UDP, 4'd5, 4'd0, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'd42));
    send_frame(mk(PROTO_UDP, 4'd5, 4'd9, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 16'd43));
    send_frame(mk(PROTO_TCP, 4'd5, 4'd5, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'hFFFF, 16'd80));
    send_frame(mk(PROTO_TCP, 4'd5, 4'd5, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'd0));
    send_frame(mk(PROTO_TCP, 4'd15, 4'd0, 32'hC0A8_0101, 32'h0808_0808, 16'd1234,
                  16'd443, 16'd100));
    send_frame(mk(PROTO_TCP, 4'd15, 4'd15, 32'h0808_0808, 32'hC0A8_0101, 16'd443,
                  16'd1234, 16'd53));
    send_frame(mk(PROTO_UDP, 4'd4, 4'd5, 32'h0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'd500));
    send_frame(mk(PROTO_UDP, 4'd5, 4'd5, 32'h5555_5555, 32'h5555_5555, 16'd53, 16'd53,
                  16'd1000));
    send_frame(mk(PROTO_UDP, 4'd5, 4'd5, 32'h5555_5555, 32'h5555_5555, 16'd53, 16'd53,
                  16'hFFFF));
    send_frame(mk(PROTO_TCP, 4'd5, 4'd5, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA,
                  16'h5555, 16'd1514));

    foreach (pool[i]) begin
      pool[i].sa = $urandom;
      pool[i].da = $urandom;
      pool[i].sp = 16'($urandom);
      pool[i].dp = 16'($urandom);
      pool[i].udp = 1'($urandom_range(0, 1));
    end

    // mostly recurring flows in either direction, plus fresh flows and noise
    repeat (RANDOM_FRAMES) begin
      r = $urandom_range(0, 99);
      k = pool[$urandom_range(0, POOL_SIZE - 1)];
      if (r < 15) begin
        k.sa = $urandom;
        k.da = $urandom;
        k.sp = 16'($urandom);
        k.dp = 16'($urandom);
        k.udp = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) pool[$urandom_range(0, POOL_SIZE - 1)] = k;
      end
      swap = 1'($urandom_range(0, 1));
      f.proto = k.udp ? PROTO_UDP : PROTO_TCP;
      f.ip_words = 4'($urandom_range(5, 15));
      f.tcp_words = 4'($urandom_range(0, 15));
      f.src_addr = swap ? k.da : k.sa;
      f.dst_addr = swap ? k.sa : k.da;
      f.from_port = swap ? k.dp : k.sp;
      f.to_port = swap ? k.sp : k.dp;
      f.frame_len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1600));
      if (r >= 70 && r < 78) begin
        f.src_addr = k.da;
        f.dst_addr = k.sa;
        f.from_port = k.sp;
        f.to_port = k.dp;
      end else if (r >= 78 && r < 85) begin
        f.proto = k.udp ? PROTO_TCP : PROTO_UDP;
      end else if (r >= 85 && r < 93) begin
        f.proto = 8'($urandom_range(0, 255));
        f.ip_words = 4'($urandom_range(0, 15));
      end else if (r >= 93) begin
        f.proto = 8'($urandom_range(0, 255));
        f.ip_words = 4'($urandom_range(0, 4));
      end
      send_frame(f);
    end
    in_valid <= 1'b0;

    while (model.pending_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Checked %0d results: %0d bad header, %0d other protocol, %0d known flow,",
             model.checked, model.by_status[bfc_pkg::STAT_BAD_IP],
             model.by_status[bfc_pkg::STAT_OTHER], model.by_status[bfc_pkg::STAT_KNOWN]);
    $display("%0d new flow; %0d flows stored, with a long output hold-off mid-run.",
             model.by_status[bfc_pkg::STAT_NEW], model.flows.size());
    if (model.errors == 0) begin
      $display("** bidirectional_flow_counter: PASSED **");
    end else begin
      $display("** bidirectional_flow_counter: FAILED **");
    end
    $finish;
  end

endmodule
